FILE: src/wrsp_pkg.sv
// ----------------------------------------------------------------------------
// wrsp_pkg
// Types and constants shared by the WAV RIFF stream parser modules.
// ----------------------------------------------------------------------------
package wrsp_pkg;

	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;
	localparam logic [31:0] TAG_LIST = 32'h5453_494C;

	localparam int FORMAT_BYTES      = 40;
	localparam int SAMPLE_BITS_FLOOR = 8;

	localparam logic [1:0] EV_SAMPLE = 2'd0;
	localparam logic [1:0] EV_START  = 2'd1;
	localparam logic [1:0] EV_DONE   = 2'd2;
	localparam logic [1:0] EV_ERROR  = 2'd3;

	localparam logic [3:0] ERR_NONE       = 4'd0;
	localparam logic [3:0] ERR_NOT_RIFF   = 4'd1;
	localparam logic [3:0] ERR_NOT_WAVE   = 4'd2;
	localparam logic [3:0] ERR_FMT_SIZE   = 4'd3;
	localparam logic [3:0] ERR_FMT_KIND   = 4'd4;
	localparam logic [3:0] ERR_CHANNELS   = 4'd5;
	localparam logic [3:0] ERR_RATE       = 4'd6;
	localparam logic [3:0] ERR_BITS       = 4'd7;
	localparam logic [3:0] ERR_NO_FMT     = 4'd8;
	localparam logic [3:0] ERR_ALIGN      = 4'd9;
	localparam logic [3:0] ERR_EARLY_END  = 4'd10;
	localparam logic [3:0] ERR_NO_DATA    = 4'd11;

	localparam logic [127:0] PCM_GUID = 128'h719B3800_AA000080_00100000_00000001;

	typedef struct packed {
		logic [7:0] file_byte;
		logic       end_of_stream;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  event_kind;
		logic [3:0]  error_code;
		logic [15:0] channel_count;
		logic [31:0] sample_rate;
		logic [6:0]  sample_bits;
		logic [18:0] frame_bytes;
		logic [31:0] speaker_mask;
		logic [7:0]  sample_byte;
		logic        last_in_chunk;
		logic [31:0] frames_total;
	} out_item_t;

	// one-hot parse phases
	typedef enum logic [6:0] {
		PH_HDR  = 7'b0000001,
		PH_CHDR = 7'b0000010,
		PH_FMT  = 7'b0000100,
		PH_DATA = 7'b0001000,
		PH_SKIP = 7'b0010000,
		PH_PAD  = 7'b0100000,
		PH_HALT = 7'b1000000
	} phase_t;

	// classified item handed from front to back
	typedef struct packed {
		logic [7:0] file_byte;
		logic       end_of_stream;
	} cls_item_t;

endpackage

FILE: src/wrsp_front.sv
// ----------------------------------------------------------------------------
// wrsp_front
// Input stage: registers accepted items into a two-entry queue for the parser.
// ----------------------------------------------------------------------------
module wrsp_front import wrsp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  stream_item,
	input  logic      push,
	output logic      full,
	output cls_item_t q_item,
	output logic      q_valid,
	input  logic      q_take
);

	cls_item_t  slot_q [2];
	logic       rd_q, wr_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	assign full    = cnt_q[1];
	assign do_push = push && !full;
	assign do_pop  = q_take && q_valid;
	assign q_valid = cnt_q != 2'd0;
	assign q_item  = slot_q[rd_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q].file_byte     <= stream_item.file_byte;
			slot_q[wr_q].end_of_stream <= stream_item.end_of_stream;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (do_pop)  rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

FILE: src/wrsp_back.sv
// ----------------------------------------------------------------------------
// wrsp_back
// Parser: walks RIFF a byte per cycle if a result slot is free; queues results.
// ----------------------------------------------------------------------------
module wrsp_back import wrsp_pkg::*; #(
	parameter int MAX_SAMPLE_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cls_item_t q_item,
	input  logic      q_valid,
	output logic      q_take,
	output out_item_t result,
	output logic      empty,
	input  logic      pop
);

	phase_t      phase_q;
	logic [3:0]  hidx_q;
	logic [31:0] tag_q, len_q, rem_q;
	logic [7:0]  fbuf_q [FORMAT_BYTES];
	logic        seen_q;
	logic [19:0] fsize_q, bif_q;
	logic [31:0] fcnt_q;

	out_item_t   res_q [2];
	logic        rrd_q, rwr_q;
	logic [1:0]  rcnt_q;

	// next-state values
	phase_t      ph_n;
	logic [3:0]  hidx_n;
	logic [31:0] tag_n, len_n, rem_n, fcnt_n;
	logic        seen_n, clr_n, wbuf, emit;
	logic [5:0]  waddr;
	logic [19:0] fsize_n, bif_n;
	out_item_t   ev;
	logic        go, pop_r;

	logic [15:0] b_tag, b_ch, b_bits, b_align;
	logic [31:0] b_rate, b_mask, pos, leff;
	logic [127:0] b_guid;
	logic [15:0] ssize;
	logic [31:0] frame;
	logic [3:0]  fmt_err;
	logic [7:0]  b;
	logic        eos;
	logic [31:0] tag_w, len_w;

	logic [7:0]  fx [FORMAT_BYTES];
	logic [127:0] fx_guid;
	logic [3:0]  last_err;
	logic        fx_we;

	// result queue: accept a byte only while a result slot is free
	assign go     = q_valid && !rcnt_q[1];
	assign q_take = go;
	assign empty  = rcnt_q == 2'd0;
	assign pop_r  = pop && !empty;
	assign result = res_q[rrd_q];

	assign b     = q_item.file_byte;
	assign eos   = q_item.end_of_stream;
	assign pos   = len_q - rem_q;
	assign waddr = pos[5:0];

	// format buffer fields
	always_comb begin
		b_tag   = {fbuf_q[1], fbuf_q[0]};
		b_ch    = {fbuf_q[3], fbuf_q[2]};
		b_rate  = {fbuf_q[7], fbuf_q[6], fbuf_q[5], fbuf_q[4]};
		b_align = {fbuf_q[13], fbuf_q[12]};
		b_bits  = {fbuf_q[15], fbuf_q[14]};
		b_mask  = {fbuf_q[23], fbuf_q[22], fbuf_q[21], fbuf_q[20]};
		for (int i = 0; i < 16; i++) b_guid[8*i +: 8] = fbuf_q[24 + i];
		ssize   = (b_bits == 16'd0) ? 16'd0 : (16'((b_bits - 16'd1) >> 3) + 16'd1);
		frame   = 32'(ssize) * 32'(b_ch);
	end

	// validation of a format held in buffer form
	function automatic logic [3:0] chk(input logic [15:0] t, input logic [15:0] c,
			input logic [31:0] r, input logic [15:0] bt, input logic [127:0] g);
		logic [3:0] e;
		e = ERR_NONE;
		if (t != 16'd1 && !(t == 16'hFFFE && g == PCM_GUID)) e = ERR_FMT_KIND;
		else if (c == 16'd0) e = ERR_CHANNELS;
		else if (r == 32'd0) e = ERR_RATE;
		else if (bt < 16'(SAMPLE_BITS_FLOOR) || bt > 16'(MAX_SAMPLE_BITS)) e = ERR_BITS;
		return e;
	endfunction

	// fmt end check: the incoming fmt byte is merged into the checked buffer
	always_comb begin
		fx_we = (phase_q == PH_FMT) && !eos && (pos < 32'(FORMAT_BYTES));
		for (int i = 0; i < FORMAT_BYTES; i++)
			fx[i] = (fx_we && waddr == 6'(i)) ? b : fbuf_q[i];
		for (int i = 0; i < 16; i++) fx_guid[8*i +: 8] = fx[24 + i];
		last_err = chk({fx[1], fx[0]}, {fx[3], fx[2]}, {fx[7], fx[6], fx[5], fx[4]},
			{fx[15], fx[14]}, fx_guid);
	end

	// parse step
	always_comb begin
		ph_n = phase_q; hidx_n = hidx_q; tag_n = tag_q; len_n = len_q; rem_n = rem_q;
		seen_n = seen_q; fsize_n = fsize_q; bif_n = bif_q; fcnt_n = fcnt_q;
		clr_n = 1'b0; wbuf = 1'b0; emit = 1'b0; ev = '0;
		leff = (len_q < 32'd4) ? 32'd4 : len_q;
		fmt_err = chk(b_tag, b_ch, b_rate, b_bits, b_guid);
		tag_w = tag_q; len_w = len_q;
		case (phase_q)
			PH_HALT: if (eos) clr_n = 1'b1;
			PH_HDR: begin
				if (eos) begin
					emit = 1'b1; ev.event_kind = EV_ERROR; ev.error_code = ERR_NOT_RIFF;
					clr_n = 1'b1;
				end else begin
					if (hidx_q < 4'd4 || hidx_q >= 4'd8) begin
						if (hidx_q == 4'd0 || hidx_q == 4'd8) tag_w = {24'd0, b};
						else tag_w[8*hidx_q[1:0] +: 8] = b;
					end
					tag_n = tag_w;
					hidx_n = hidx_q + 4'd1;
					if (hidx_q == 4'd3 && tag_w != TAG_RIFF) begin
						emit = 1'b1; ev.event_kind = EV_ERROR; ev.error_code = ERR_NOT_RIFF;
						ph_n = PH_HALT;
					end else if (hidx_q >= 4'd11) begin
						if (tag_w != TAG_WAVE) begin
							emit = 1'b1; ev.event_kind = EV_ERROR;
							ev.error_code = ERR_NOT_WAVE; ph_n = PH_HALT;
						end else begin
							ph_n = PH_CHDR; hidx_n = 4'd0;
						end
					end
				end
			end
			PH_CHDR: begin
				if (eos) begin
					emit = 1'b1; clr_n = 1'b1;
					if (!seen_q) begin
						ev.event_kind = EV_ERROR; ev.error_code = ERR_NO_DATA;
					end else begin
						ev.event_kind = EV_DONE; ev.frames_total = fcnt_q;
					end
				end else begin
					if (hidx_q < 4'd4) begin
						if (hidx_q == 4'd0) tag_w = {24'd0, b};
						else tag_w[8*hidx_q[1:0] +: 8] = b;
					end else begin
						if (hidx_q == 4'd4) len_w = {24'd0, b};
						else len_w[8*hidx_q[1:0] +: 8] = b;
					end
					tag_n = tag_w; len_n = len_w;
					hidx_n = hidx_q + 4'd1;
					if (hidx_q >= 4'd7) begin
						hidx_n = 4'd0;
						if (tag_w == TAG_FMT) begin
							if (len_w > 32'(FORMAT_BYTES)) begin
								emit = 1'b1; ev.event_kind = EV_ERROR;
								ev.error_code = ERR_FMT_SIZE; ph_n = PH_HALT;
							end else if (len_w == 32'd0) begin
								if (fmt_err != ERR_NONE) begin
									emit = 1'b1; ev.event_kind = EV_ERROR;
									ev.error_code = fmt_err; ph_n = PH_HALT;
								end else ph_n = PH_CHDR;
							end else begin
								ph_n = PH_FMT; rem_n = len_w;
							end
						end else if (tag_w == TAG_DATA) begin
							if (b_tag == 16'd0) begin
								emit = 1'b1; ev.event_kind = EV_ERROR;
								ev.error_code = ERR_NO_FMT; ph_n = PH_HALT;
							end else if (32'(b_align) != frame) begin
								emit = 1'b1; ev.event_kind = EV_ERROR;
								ev.error_code = ERR_ALIGN; ph_n = PH_HALT;
							end else begin
								fsize_n = frame[19:0]; bif_n = '0; fcnt_n = '0;
								emit = 1'b1; ev.event_kind = EV_START;
								ev.channel_count = b_ch; ev.sample_rate = b_rate;
								ev.sample_bits = b_bits[6:0]; ev.frame_bytes = frame[18:0];
								ev.speaker_mask = b_mask;
								if (len_w == 32'd0) begin
									seen_n = 1'b1; ph_n = PH_CHDR;
								end else begin
									ph_n = PH_DATA; rem_n = len_w;
								end
							end
						end else if (tag_w == TAG_LIST) begin
							ph_n = PH_SKIP;
							rem_n = (len_w < 32'd4) ? 32'd4 : len_w;
						end else if (len_w == 32'd0) begin
							ph_n = PH_CHDR;
						end else begin
							ph_n = PH_SKIP; rem_n = len_w;
						end
					end
				end
			end
			PH_FMT: begin
				if (eos) begin
					emit = 1'b1; ev.event_kind = EV_ERROR; ev.error_code = ERR_EARLY_END;
					clr_n = 1'b1;
				end else begin
					wbuf = pos < 32'(FORMAT_BYTES);
					rem_n = rem_q - 32'd1;
					if (rem_n == 32'd0) begin
						// last fmt byte: validate with that byte already in place
						hidx_n = 4'd0;
						if (last_err != ERR_NONE) begin
							emit = 1'b1; ev.event_kind = EV_ERROR;
							ev.error_code = last_err; ph_n = PH_HALT;
						end else begin
							ph_n = len_q[0] ? PH_PAD : PH_CHDR;
						end
					end
				end
			end
			PH_DATA: begin
				if (eos) begin
					emit = 1'b1; ev.event_kind = EV_ERROR; ev.error_code = ERR_EARLY_END;
					clr_n = 1'b1;
				end else begin
					emit = 1'b1; ev.event_kind = EV_SAMPLE; ev.sample_byte = b;
					ev.last_in_chunk = rem_q == 32'd1;
					bif_n = bif_q + 20'd1;
					if (fsize_q != 20'd0 && bif_n >= fsize_q) begin
						bif_n = '0; fcnt_n = fcnt_q + 32'd1;
					end
					rem_n = rem_q - 32'd1;
					if (rem_n == 32'd0) begin
						seen_n = 1'b1;
						ph_n = len_q[0] ? PH_PAD : PH_CHDR; hidx_n = 4'd0;
					end
				end
			end
			PH_SKIP: begin
				if (eos) begin
					emit = 1'b1; clr_n = 1'b1;
					if (tag_q == TAG_LIST && (leff - rem_q) < 32'd4) begin
						ev.event_kind = EV_ERROR; ev.error_code = ERR_EARLY_END;
					end else if (!seen_q) begin
						ev.event_kind = EV_ERROR; ev.error_code = ERR_NO_DATA;
					end else begin
						ev.event_kind = EV_DONE; ev.frames_total = fcnt_q;
					end
				end else begin
					rem_n = rem_q - 32'd1;
					if (rem_n == 32'd0) begin
						ph_n = len_q[0] ? PH_PAD : PH_CHDR; hidx_n = 4'd0;
					end
				end
			end
			PH_PAD: begin
				if (eos) begin
					emit = 1'b1; clr_n = 1'b1;
					if (!seen_q) begin
						ev.event_kind = EV_ERROR; ev.error_code = ERR_NO_DATA;
					end else begin
						ev.event_kind = EV_DONE; ev.frames_total = fcnt_q;
					end
				end else begin
					ph_n = PH_CHDR; hidx_n = 4'd0;
				end
			end
			default: clr_n = 1'b1;
		endcase
	end

	// parser registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR; hidx_q <= '0; tag_q <= '0; len_q <= '0; rem_q <= '0;
			seen_q <= 1'b0; fsize_q <= '0; bif_q <= '0; fcnt_q <= '0;
			for (int i = 0; i < FORMAT_BYTES; i++) fbuf_q[i] <= '0;
		end else if (go) begin
			if (clr_n) begin
				phase_q <= PH_HDR; hidx_q <= '0; tag_q <= '0; len_q <= '0; rem_q <= '0;
				seen_q <= 1'b0; fsize_q <= '0; bif_q <= '0; fcnt_q <= '0;
				for (int i = 0; i < FORMAT_BYTES; i++) fbuf_q[i] <= '0;
			end else begin
				phase_q <= ph_n; hidx_q <= hidx_n; tag_q <= tag_n; len_q <= len_n;
				rem_q <= rem_n; seen_q <= seen_n; fsize_q <= fsize_n; bif_q <= bif_n;
				fcnt_q <= fcnt_n;
				if (wbuf) fbuf_q[waddr] <= b;
			end
		end
	end

	// result queue
	always_ff @(posedge clk) begin
		if (go && emit) res_q[rwr_q] <= ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rrd_q <= 1'b0; rwr_q <= 1'b0; rcnt_q <= 2'd0;
		end else begin
			if (go && emit) rwr_q <= !rwr_q;
			if (pop_r) rrd_q <= !rrd_q;
			rcnt_q <= rcnt_q + {1'b0, go && emit} - {1'b0, pop_r};
		end
	end

endmodule

FILE: src/wav_riff_stream_parser.sv
// An accepted item is registered in the front queue; when the parser takes it, any
// result is registered in the result queue. Throughput: one byte per cycle, set by
// the single-byte parse step in wrsp_back, while a result slot is free.
// Both sides hold two-entry queues, so either side may stall independently.
// Reset (arst_n low) empties both queues and returns the parser to the file
// header with a cleared format buffer; no clearing pass is needed.
// ----------------------------------------------------------------------------
// wav_riff_stream_parser
// Top level: byte queue front end feeding the RIFF/WAVE parser back end.
// ----------------------------------------------------------------------------
module wav_riff_stream_parser import wrsp_pkg::*; #(
	parameter int MAX_SAMPLE_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  stream_item,
	input  logic      push,
	output logic      full,
	output out_item_t result,
	output logic      empty,
	input  logic      pop
);

	cls_item_t q_item;
	logic      q_valid, q_take;

	wrsp_front u_front (
		.clk, .arst_n, .stream_item, .push, .full,
		.q_item, .q_valid, .q_take
	);

	wrsp_back #(.MAX_SAMPLE_BITS(MAX_SAMPLE_BITS)) u_back (
		.clk, .arst_n, .q_item, .q_valid, .q_take,
		.result, .empty, .pop
	);

endmodule
